FILE: hdl/tft_pkg.sv
// ----------------------------------------------------------------------------
// Twist frame transform package
// Shared constants for the twist frame transform: fixed-point formats,
// configuration register map and register reset values.
// ----------------------------------------------------------------------------
package tft_pkg;

    // Default width of every vector component (Q(DATA_WIDTH-16).16).
    localparam int DEF_DATA_WIDTH = 32;

    // Rotation entries are Q2.14, three of them packed into one 48-bit row.
    localparam int ROT_W     = 16;
    localparam int ROT_FRAC  = 14;
    localparam int ROW_W     = 3 * ROT_W;
    localparam int FRAC_BITS = 16;

    // Configuration port: 64-bit data, registers on 8-byte boundaries.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_IDX_W  = 3;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS_Z  = 3'd5;

    // Reset rotation is the identity: 1.0 (16384) on the diagonal.
    localparam logic [ROW_W-1:0] ROT_ROW0_RST = 48'h0000_0000_4000;
    localparam logic [ROW_W-1:0] ROT_ROW1_RST = 48'h0000_4000_0000;
    localparam logic [ROW_W-1:0] ROT_ROW2_RST = 48'h4000_0000_0000;

endpackage

FILE: hdl/twist_frame_transform.sv
// ----------------------------------------------------------------------------
// Twist frame transform
// Maps a spatial motion vector (angular w, linear v) through a rigid
// transform (R, p): angular out = R*w, linear out = p x (R*w) + R*v.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on the slave stream (i_s_tvalid / o_s_tready /
// i_s_tdata) as six signed Q16.16 components, results leave on the master
// stream (o_m_tvalid / i_m_tready / o_m_tdata) in the same packing. The
// rotation rows (Q2.14) and the translation (Q16.16) sit in registers on the
// APB-style port and must only be written while no item is in flight.
// The datapath is a five-stage pipeline: products of R with w and v, row
// sums with shift and saturation of R*w, cross-product partial products,
// cross-product combine, and the final add, shift and saturation that
// loads the output register. One item can be accepted in every cycle while
// the pipeline has room.
// Each stage holds its item until the next stage has room, so a stall on
// the master side fills the empty stages first; o_s_tready falls only when
// all five stages hold an item. Nothing is lost or repeated across a stall.
// A synchronous reset empties the pipeline and restores the identity
// rotation and a zero translation.
// ----------------------------------------------------------------------------
module twist_frame_transform #(
    parameter int DATA_WIDTH = tft_pkg::DEF_DATA_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Slave stream, input items.
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // Fields from bit 0 up: ang_x, ang_y, ang_z, lin_x, lin_y, lin_z.
    input  logic [((6*DATA_WIDTH+7)/8)*8-1:0]     i_s_tdata,
    // Master stream, result items.
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // Fields from bit 0 up: out_ang_x, out_ang_y, out_ang_z,
    // out_lin_x, out_lin_y, out_lin_z.
    output logic [((6*DATA_WIDTH+7)/8)*8-1:0]     o_m_tdata,
    // Configuration port.
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [tft_pkg::CFG_ADDR_W-1:0]        paddr,
    input  logic [tft_pkg::CFG_DATA_W-1:0]        pwdata,
    output logic [tft_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                  pready
);
    import tft_pkg::*;

    localparam int DW      = DATA_WIDTH;
    localparam int TDATA_W = ((6 * DW + 7) / 8) * 8;
    localparam int NSTG    = 5;
    // R times a component, and the sum of three of them.
    localparam int PW      = DW + ROT_W;
    localparam int SW      = PW + 2;
    localparam int UW      = SW - ROT_FRAC;
    // The cross product splits u into a signed high half and an unsigned
    // low half so that each multiplier stays narrow.
    localparam int H       = DW / 2;
    localparam int HW      = DW - H;
    localparam int P3H     = DW + HW;
    localparam int P3L     = DW + H + 1;
    localparam int CW      = 2 * DW + 2;
    localparam int TW      = 2 * DW + 5;
    localparam int LW      = TW - FRAC_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]     r_rot   [3];
    logic [DW-1:0]        r_trans [3];
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic                 cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0]   <= ROT_ROW0_RST;
            r_rot[1]   <= ROT_ROW1_RST;
            r_rot[2]   <= ROT_ROW2_RST;
            r_trans[0] <= '0;
            r_trans[1] <= '0;
            r_trans[2] <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ROT_ROW0: r_rot[0]   <= pwdata[ROW_W-1:0];
                REG_ROT_ROW1: r_rot[1]   <= pwdata[ROW_W-1:0];
                REG_ROT_ROW2: r_rot[2]   <= pwdata[ROW_W-1:0];
                REG_TRANS_X:  r_trans[0] <= pwdata[DW-1:0];
                REG_TRANS_Y:  r_trans[1] <= pwdata[DW-1:0];
                REG_TRANS_Z:  r_trans[2] <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ROT_ROW0: prdata = CFG_DATA_W'(r_rot[0]);
            REG_ROT_ROW1: prdata = CFG_DATA_W'(r_rot[1]);
            REG_ROT_ROW2: prdata = CFG_DATA_W'(r_rot[2]);
            REG_TRANS_X:  prdata = CFG_DATA_W'(r_trans[0]);
            REG_TRANS_Y:  prdata = CFG_DATA_W'(r_trans[1]);
            REG_TRANS_Z:  prdata = CFG_DATA_W'(r_trans[2]);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Saturation to a DW-bit signed value
    // ------------------------------------------------------------------
    function automatic logic [DW-1:0] sat_ang(input logic [UW-1:0] x);
        logic [UW-DW:0] top;
        top = x[UW-1:DW-1];
        if (top == '0 || top == '1) begin
            return x[DW-1:0];
        end else if (x[UW-1]) begin
            return {1'b1, {(DW-1){1'b0}}};
        end else begin
            return {1'b0, {(DW-1){1'b1}}};
        end
    endfunction

    function automatic logic [DW-1:0] sat_lin(input logic [LW-1:0] x);
        logic [LW-DW:0] top;
        top = x[LW-1:DW-1];
        if (top == '0 || top == '1) begin
            return x[DW-1:0];
        end else if (x[LW-1]) begin
            return {1'b1, {(DW-1){1'b0}}};
        end else begin
            return {1'b0, {(DW-1){1'b1}}};
        end
    endfunction

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or when the
    // stage after it loads in the same cycle.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] adv;

    always_comb begin
        adv[NSTG-1] = !r_vld[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_tready = adv[0];
    assign o_m_tvalid = r_vld[NSTG-1];

    // ------------------------------------------------------------------
    // Stage 1: the eighteen products of R with w and with v.
    // ------------------------------------------------------------------
    logic signed [DW-1:0]    w_in   [3];
    logic signed [DW-1:0]    v_in   [3];
    logic signed [ROT_W-1:0] rot_e  [3][3];
    logic signed [PW-1:0]    n_s1_pw [3][3];
    logic signed [PW-1:0]    n_s1_pv [3][3];
    logic signed [PW-1:0]    r_s1_pw [3][3];
    logic signed [PW-1:0]    r_s1_pv [3][3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_in[c] = $signed(i_s_tdata[c*DW +: DW]);
            v_in[c] = $signed(i_s_tdata[(c+3)*DW +: DW]);
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                rot_e[r][c]   = $signed(r_rot[r][c*ROT_W +: ROT_W]);
                n_s1_pw[r][c] = PW'(rot_e[r][c]) * PW'(w_in[c]);
                n_s1_pv[r][c] = PW'(rot_e[r][c]) * PW'(v_in[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s1_pw <= n_s1_pw;
            r_s1_pv <= n_s1_pv;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: row sums; R*w is shifted back to Q16.16 and saturated,
    // R*v stays exact in Q.30.
    // ------------------------------------------------------------------
    logic signed [SW-1:0] sum_w  [3];
    logic signed [SW-1:0] n_s2_rv [3];
    logic signed [DW-1:0] n_s2_u  [3];
    logic signed [SW-1:0] r_s2_rv [3];
    logic signed [DW-1:0] r_s2_u  [3];

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sum_w[r]   = SW'(r_s1_pw[r][0]) + SW'(r_s1_pw[r][1]) + SW'(r_s1_pw[r][2]);
            n_s2_rv[r] = SW'(r_s1_pv[r][0]) + SW'(r_s1_pv[r][1]) + SW'(r_s1_pv[r][2]);
            n_s2_u[r]  = $signed(sat_ang(sum_w[r][SW-1:ROT_FRAC]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_s2_rv <= n_s2_rv;
            r_s2_u  <= n_s2_u;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: partial products of p[a]*u[b] and p[b]*u[a], where a and b
    // are the two components that follow the output component cyclically.
    // ------------------------------------------------------------------
    logic signed [DW-1:0]  p_s    [3];
    logic signed [HW-1:0]  u_hi   [3];
    logic signed [H:0]     u_lo   [3];
    logic signed [P3H-1:0] n_s3_ah [3];
    logic signed [P3L-1:0] n_s3_al [3];
    logic signed [P3H-1:0] n_s3_bh [3];
    logic signed [P3L-1:0] n_s3_bl [3];
    logic signed [P3H-1:0] r_s3_ah [3];
    logic signed [P3L-1:0] r_s3_al [3];
    logic signed [P3H-1:0] r_s3_bh [3];
    logic signed [P3L-1:0] r_s3_bl [3];
    logic signed [SW-1:0]  r_s3_rv [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p_s[i]  = $signed(r_trans[i]);
            u_hi[i] = $signed(r_s2_u[i][DW-1:H]);
            u_lo[i] = $signed({1'b0, r_s2_u[i][H-1:0]});
        end
        for (int i = 0; i < 3; i++) begin
            int a;
            int b;
            a = (i == 2) ? 0 : i + 1;
            b = (i == 0) ? 2 : i - 1;
            n_s3_ah[i] = P3H'(p_s[a]) * P3H'(u_hi[b]);
            n_s3_al[i] = P3L'(p_s[a]) * P3L'(u_lo[b]);
            n_s3_bh[i] = P3H'(p_s[b]) * P3H'(u_hi[a]);
            n_s3_bl[i] = P3L'(p_s[b]) * P3L'(u_lo[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_s3_ah <= n_s3_ah;
            r_s3_al <= n_s3_al;
            r_s3_bh <= n_s3_bh;
            r_s3_bl <= n_s3_bl;
            r_s3_rv <= r_s2_rv;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: combine the halves into the exact Q.32 cross product.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] n_s4_cr [3];
    logic signed [CW-1:0] r_s4_cr [3];
    logic signed [SW-1:0] r_s4_rv [3];
    logic signed [DW-1:0] r_s4_u  [3];
    logic signed [DW-1:0] r_s3_u  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s4_cr[i] = (CW'(r_s3_ah[i]) <<< H) + CW'(r_s3_al[i])
                       - (CW'(r_s3_bh[i]) <<< H) - CW'(r_s3_bl[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_s3_u <= r_s2_u;
        end
        if (adv[3]) begin
            r_s4_cr <= n_s4_cr;
            r_s4_rv <= r_s3_rv;
            r_s4_u  <= r_s3_u;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: add 4*R*v (Q.30 to Q.32), shift to Q16.16 with rounding
    // toward minus infinity, saturate and load the output register.
    // ------------------------------------------------------------------
    logic signed [TW-1:0] tot   [3];
    logic        [DW-1:0] n_lin [3];
    logic        [DW-1:0] r_out_ang [3];
    logic        [DW-1:0] r_out_lin [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            tot[i]   = TW'(r_s4_cr[i]) + (TW'(r_s4_rv[i]) <<< 2);
            n_lin[i] = sat_lin(tot[i][TW-1:FRAC_BITS]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            for (int i = 0; i < 3; i++) begin
                r_out_ang[i] <= r_s4_u[i];
                r_out_lin[i] <= n_lin[i];
            end
        end
    end

    assign o_m_tdata = TDATA_W'({r_out_lin[2], r_out_lin[1], r_out_lin[0],
                                 r_out_ang[2], r_out_ang[1], r_out_ang[0]});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Input back-pressure only when every stage is full and the output stalls.
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_vld == '1) && !i_m_tready)
        else $error("input stalled while the pipeline has room");

    // An accepted item occupies the first stage on the next cycle.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[0])
        else $error("accepted item was lost at the first stage");

    // An item leaving the fourth stage reaches the output register.
    a_last_hop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && adv[4]) |=> o_m_tvalid)
        else $error("item lost between the last two stages");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && (r_vld == '0))
        else $error("pipeline not empty after reset");

endmodule
